FILE: rtl/stb_pkg.sv
// package for the software timer bank: sizes, codes, word layout and the
// structs passed between the controller and the timer cells
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package stb_pkg;

  localparam int NUM_TIMERS = 16;
  // indices are 4 bits wide, so at most 16 timers are reachable
  localparam int BANK_SIZE  = (NUM_TIMERS < 16) ? NUM_TIMERS : 16;

  localparam int IDX_W    = 4;
  localparam int MS_W     = 32;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // slave word layout
  localparam int IN_IDX_LSB     = 0;
  localparam int IN_TIMEOUT_LSB = IN_IDX_LSB + IDX_W;
  localparam int IN_TICK_LSB    = IN_TIMEOUT_LSB + MS_W;
  localparam int IN_FLAG_LSB    = IN_TICK_LSB + MS_W;
  localparam int IN_BITS        = IN_FLAG_LSB + 1;
  localparam int S_TDATA_W      = ((IN_BITS + 7) / 8) * 8;

  // master word layout
  localparam int OUT_IDX_LSB   = 0;
  localparam int OUT_ACT_LSB   = OUT_IDX_LSB + IDX_W;
  localparam int OUT_SUS_LSB   = OUT_ACT_LSB + 1;
  localparam int OUT_COUNT_LSB = OUT_SUS_LSB + 1;
  localparam int OUT_MIN_LSB   = OUT_COUNT_LSB + COUNT_W;
  localparam int OUT_BITS      = OUT_MIN_LSB + MS_W;
  localparam int M_TDATA_W     = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 3'd0,
    CMD_FREE    = 3'd1,
    CMD_ARM     = 3'd2,
    CMD_CANCEL  = 3'd3,
    CMD_SUSPEND = 3'd4,
    CMD_TICK    = 3'd5,
    CMD_QUERY   = 3'd6
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXPIRED   = 2'd1,
    ST_NO_FREE   = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_QUERY = 2'd2
  } sweep_op_t;

  typedef enum logic [2:0] {
    CC_NONE    = 3'd0,
    CC_FREE    = 3'd1,
    CC_ARM     = 3'd2,
    CC_CANCEL  = 3'd3,
    CC_SUSPEND = 3'd4
  } cc_kind_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_SWEEP = 1'b1
  } state_t;

  // token and running result handed from cell to cell during a sweep
  typedef struct packed {
    logic             tok;
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [MS_W-1:0]  minv;
  } link_t;

  // single-timer command broadcast to every cell
  typedef struct packed {
    cc_kind_t         kind;
    logic [IDX_W-1:0] index;
    logic [MS_W-1:0]  timeout;
    logic             flag;
  } cell_cmd_t;

  typedef struct packed {
    logic hit;
    logic alloc;
    logic armed;
    logic susp;
  } cell_stat_t;

endpackage

`default_nettype wire

FILE: rtl/software_timer_bank.sv
// Bank of BANK_SIZE countdown timers held in a row of cells. Free, arm,
// cancel, suspend and unused commands give one word. Alloc, tick and query
// send a token down the cell row, one cell per cycle while the master
// side does not stall, then give a closing word; a tick gives one expiry
// word per timer that runs out, in index order, as the token passes it, then
// a done word with tlast set. A new command is taken once the previous one
// has finished and the result register is free or being emptied.
// depends on stb_pkg, stb_cell and stb_ctrl
`timescale 1ns / 1ps
`default_nettype none

module software_timer_bank import stb_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // timer_index, timeout_ms, tick_ms, suspend_flag
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  // cmd
  input  wire logic [CMD_W-1:0]     s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // result_index, is_active, is_suspended, alloc_count, min_wait
  output logic [M_TDATA_W-1:0]      m_tdata,
  // status
  output logic [STATUS_W-1:0]       m_tuser,
  output logic                      m_tlast
);

  link_t      link [BANK_SIZE+1];
  cell_stat_t stat [BANK_SIZE];
  logic [BANK_SIZE-1:0] expire_vec;
  logic [BANK_SIZE-1:0] alloc_vec;
  logic [BANK_SIZE:0]   tok_vec;

  cell_stat_t       sel_stat;
  logic             expire_any;
  logic [IDX_W-1:0] expire_idx;
  logic             adv;
  sweep_op_t        op;
  logic [MS_W-1:0]  tick_val;
  cell_cmd_t        ccmd;

  stb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .sel_stat   (sel_stat),
    .expire_any (expire_any),
    .expire_idx (expire_idx),
    .tail       (link[BANK_SIZE]),
    .head       (link[0]),
    .adv        (adv),
    .op         (op),
    .tick_val   (tick_val),
    .ccmd       (ccmd)
  );

  for (genvar i = 0; i < BANK_SIZE; i++) begin : g_cell
    stb_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_id   (IDX_W'(i)),
      .adv       (adv),
      .op        (op),
      .tick_ms   (tick_val),
      .ccmd      (ccmd),
      .carry_in  (link[i]),
      .carry_out (link[i+1]),
      .stat      (stat[i]),
      .expire    (expire_vec[i])
    );
  end

  // only one cell is ever addressed or holds the token, so plain or-ing picks it
  always_comb begin
    sel_stat   = '0;
    expire_idx = '0;
    for (int i = 0; i < BANK_SIZE; i++) begin
      sel_stat.hit   = sel_stat.hit   | stat[i].hit;
      sel_stat.alloc = sel_stat.alloc | (stat[i].hit & stat[i].alloc);
      sel_stat.armed = sel_stat.armed | (stat[i].hit & stat[i].armed);
      sel_stat.susp  = sel_stat.susp  | (stat[i].hit & stat[i].susp);
      expire_idx     = expire_idx | (expire_vec[i] ? IDX_W'(i) : '0);
      alloc_vec[i]   = stat[i].alloc;
    end
    for (int i = 0; i <= BANK_SIZE; i++) begin
      tok_vec[i] = link[i].tok;
    end
  end

  assign expire_any = |expire_vec;

  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(tok_vec))
    else $error("more than one sweep token in the cell row");

  a_idle_no_token: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (tok_vec == '0))
    else $error("command taken while a sweep is still running");

  a_sweep_launch: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == CMD_TICK || s_tuser == CMD_ALLOC ||
     s_tuser == CMD_QUERY)) |=> tok_vec[0])
    else $error("sweep command did not launch a token");

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (int'(m_tdata[OUT_COUNT_LSB +: COUNT_W]) == $countones(alloc_vec)))
    else $error("reported allocation count differs from allocated cells");

endmodule

`default_nettype wire

FILE: rtl/stb_cell.sv
// one timer cell of the chain: timer state plus one stage of the sweep
// depends on stb_pkg
`timescale 1ns / 1ps
`default_nettype none

module stb_cell import stb_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [IDX_W-1:0] cell_id,
  input  wire logic             adv,
  input  wire sweep_op_t        op,
  input  wire logic [MS_W-1:0]  tick_ms,
  input  wire cell_cmd_t        ccmd,
  input  wire link_t            carry_in,
  output link_t                 carry_out,
  output cell_stat_t            stat,
  output logic                  expire
);

  logic            alloc;
  logic            armed;
  logic            susp;
  logic [MS_W-1:0] remaining;

  logic             tok;
  logic             found;
  logic [IDX_W-1:0] idx;
  logic [MS_W-1:0]  minv;

  logic             found_next;
  logic [IDX_W-1:0] idx_next;
  logic [MS_W-1:0]  minv_next;

  logic counting;
  logic fits;
  logic take;
  logic claim;
  logic cmd_hit;

  assign counting = alloc & armed & ~susp;
  assign fits     = (remaining <= tick_ms);
  assign take     = adv & carry_in.tok;
  assign claim    = ~carry_in.found & ~alloc;
  assign cmd_hit  = (ccmd.index == cell_id) && (ccmd.kind != CC_NONE);

  assign expire    = carry_in.tok && (op == OP_TICK) && counting && fits;
  assign stat      = '{hit: (ccmd.index == cell_id), alloc: alloc, armed: armed, susp: susp};
  assign carry_out = '{tok: tok, found: found, idx: idx, minv: minv};

  // running result handed on to the next cell
  always_comb begin
    found_next = carry_in.found;
    idx_next   = carry_in.idx;
    minv_next  = carry_in.minv;
    case (op)
      OP_ALLOC: begin
        if (claim) begin
          found_next = 1'b1;
          idx_next   = cell_id;
        end
      end
      OP_QUERY: begin
        if (counting && (!carry_in.found || remaining < carry_in.minv)) begin
          found_next = 1'b1;
          minv_next  = remaining;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alloc <= 1'b0;
      armed <= 1'b0;
      susp  <= 1'b0;
      tok   <= 1'b0;
    end else begin
      if (adv) begin
        tok <= carry_in.tok;
      end
      if (cmd_hit) begin
        case (ccmd.kind)
          CC_FREE: begin
            alloc <= 1'b0;
            armed <= 1'b0;
            susp  <= 1'b0;
          end
          CC_ARM:     armed <= 1'b1;
          CC_CANCEL:  armed <= 1'b0;
          CC_SUSPEND: susp  <= ccmd.flag;
          default: ;
        endcase
      end
      if (take) begin
        case (op)
          OP_TICK: begin
            if (counting && fits) armed <= 1'b0;
          end
          OP_ALLOC: begin
            // first free cell along the chain takes the allocation
            if (claim) begin
              alloc <= 1'b1;
              armed <= 1'b0;
              susp  <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_hit) begin
      case (ccmd.kind)
        CC_FREE:   remaining <= '0;
        CC_ARM:    remaining <= ccmd.timeout;
        CC_CANCEL: remaining <= '0;
        default: ;
      endcase
    end
    if (take) begin
      found <= found_next;
      idx   <= idx_next;
      minv  <= minv_next;
      case (op)
        OP_TICK: begin
          if (counting) remaining <= fits ? '0 : remaining - tick_ms;
        end
        OP_ALLOC: begin
          if (claim) remaining <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/stb_ctrl.sv
// command decoder, sweep launcher and result register of the timer bank
// depends on stb_pkg
`timescale 1ns / 1ps
`default_nettype none

module stb_ctrl import stb_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  input  wire logic [CMD_W-1:0]     s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata,
  output logic [STATUS_W-1:0]       m_tuser,
  output logic                      m_tlast,
  input  wire cell_stat_t           sel_stat,
  input  wire logic                 expire_any,
  input  wire logic [IDX_W-1:0]     expire_idx,
  input  wire link_t                tail,
  output link_t                     head,
  output logic                      adv,
  output sweep_op_t                 op,
  output logic [MS_W-1:0]           tick_val,
  output cell_cmd_t                 ccmd
);

  state_t    state, state_next;
  sweep_op_t op_next;
  logic [MS_W-1:0] tick_next;
  logic            head_tok, head_tok_next;
  logic [COUNT_W-1:0] total, total_next;
  logic q_bad, q_bad_next;
  logic q_act, q_act_next;
  logic q_sus, q_sus_next;

  logic                m_tvalid_next;
  status_t             o_status, o_status_next;
  logic [IDX_W-1:0]    o_idx, o_idx_next;
  logic                o_act, o_act_next;
  logic                o_sus, o_sus_next;
  logic [COUNT_W-1:0]  o_count, o_count_next;
  logic [MS_W-1:0]     o_min, o_min_next;
  logic                o_last, o_last_next;

  logic     out_free;
  logic     accept;
  logic     load;
  status_t  r_status;
  logic [IDX_W-1:0] r_idx;
  logic     r_act;
  logic     r_sus;
  logic [MS_W-1:0] r_min;
  logic     r_last;
  cc_kind_t kind;
  logic     valid_idx;

  assign out_free  = ~m_tvalid | m_tready;
  assign s_tready  = (state == S_IDLE) && out_free;
  assign accept    = s_tvalid & s_tready;
  assign adv       = (state == S_SWEEP) && out_free;
  assign valid_idx = sel_stat.hit & sel_stat.alloc;

  assign head = '{tok: head_tok, found: 1'b0, idx: '0, minv: '0};
  assign ccmd = '{kind: kind, index: s_tdata[IN_IDX_LSB +: IDX_W],
                  timeout: s_tdata[IN_TIMEOUT_LSB +: MS_W], flag: s_tdata[IN_FLAG_LSB]};

  assign m_tuser = o_status;
  assign m_tlast = o_last;
  assign m_tdata = {{(M_TDATA_W - OUT_BITS){1'b0}}, o_min, o_count, o_sus, o_act, o_idx};

  always_comb begin
    state_next    = state;
    op_next       = op;
    tick_next     = tick_val;
    head_tok_next = head_tok;
    total_next    = total;
    q_bad_next    = q_bad;
    q_act_next    = q_act;
    q_sus_next    = q_sus;
    kind          = CC_NONE;
    load          = 1'b0;
    r_status      = ST_OK;
    r_idx         = '0;
    r_act         = 1'b0;
    r_sus         = 1'b0;
    r_min         = '0;
    r_last        = 1'b1;

    if (adv && head_tok) head_tok_next = 1'b0;

    if (accept) begin
      case (cmd_t'(s_tuser))
        CMD_ALLOC: begin
          state_next    = S_SWEEP;
          op_next       = OP_ALLOC;
          head_tok_next = 1'b1;
        end
        CMD_TICK: begin
          state_next    = S_SWEEP;
          op_next       = OP_TICK;
          tick_next     = s_tdata[IN_TICK_LSB +: MS_W];
          head_tok_next = 1'b1;
        end
        CMD_QUERY: begin
          state_next    = S_SWEEP;
          op_next       = OP_QUERY;
          head_tok_next = 1'b1;
          q_bad_next    = ~valid_idx;
          q_act_next    = valid_idx & sel_stat.armed;
          q_sus_next    = valid_idx & sel_stat.susp;
        end
        CMD_FREE: begin
          load = 1'b1;
          if (valid_idx) begin
            kind = CC_FREE;
            if (total != '0) total_next = total - 1'b1;
          end else begin
            r_status = ST_BAD_INDEX;
          end
        end
        CMD_ARM: begin
          load = 1'b1;
          if (valid_idx) kind = CC_ARM;
          else r_status = ST_BAD_INDEX;
        end
        CMD_CANCEL: begin
          load = 1'b1;
          if (valid_idx) kind = CC_CANCEL;
          else r_status = ST_BAD_INDEX;
        end
        CMD_SUSPEND: begin
          load = 1'b1;
          if (valid_idx) kind = CC_SUSPEND;
          else r_status = ST_BAD_INDEX;
        end
        default: begin
          // unused code: plain ok word
          load = 1'b1;
        end
      endcase
    end else if (adv) begin
      if (expire_any) begin
        load     = 1'b1;
        r_status = ST_EXPIRED;
        r_idx    = expire_idx;
        r_last   = 1'b0;
      end else if (tail.tok) begin
        // token has left the last cell: closing word of the command
        load       = 1'b1;
        state_next = S_IDLE;
        case (op)
          OP_ALLOC: begin
            if (tail.found) begin
              r_idx      = tail.idx;
              total_next = total + 1'b1;
            end else begin
              r_status = ST_NO_FREE;
            end
          end
          OP_QUERY: begin
            r_status = q_bad ? ST_BAD_INDEX : ST_OK;
            r_act    = q_act;
            r_sus    = q_sus;
            r_min    = tail.found ? tail.minv : '0;
          end
          default: ;
        endcase
      end
    end

    m_tvalid_next = m_tvalid & ~m_tready;
    o_status_next = o_status;
    o_idx_next    = o_idx;
    o_act_next    = o_act;
    o_sus_next    = o_sus;
    o_count_next  = o_count;
    o_min_next    = o_min;
    o_last_next   = o_last;
    if (load) begin
      m_tvalid_next = 1'b1;
      o_status_next = r_status;
      o_idx_next    = r_idx;
      o_act_next    = r_act;
      o_sus_next    = r_sus;
      o_count_next  = total_next;
      o_min_next    = r_min;
      o_last_next   = r_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head_tok <= 1'b0;
      total    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      head_tok <= head_tok_next;
      total    <= total_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    tick_val <= tick_next;
    q_bad    <= q_bad_next;
    q_act    <= q_act_next;
    q_sus    <= q_sus_next;
    o_status <= o_status_next;
    o_idx    <= o_idx_next;
    o_act    <= o_act_next;
    o_sus    <= o_sus_next;
    o_count  <= o_count_next;
    o_min    <= o_min_next;
    o_last   <= o_last_next;
  end

endmodule

`default_nettype wire
